// ===== rtl/nvmt_pkg.sv =====
// ----------------------------------------------------------------------------
// nvmt_pkg
// Shared types and constants for the nearest vector threshold match core.
// ----------------------------------------------------------------------------
package nvmt_pkg;

  localparam int unsigned VAL_W  = 16;
  localparam int unsigned ID_W   = 31;
  localparam int unsigned ACC_W  = 48;
  localparam int unsigned DIFF_W = VAL_W + 1;
  localparam int unsigned MAG_W  = VAL_W;
  localparam int unsigned SQ_W   = 2 * MAG_W;
  localparam int unsigned ECNT_W = 8;

  localparam logic [ACC_W-1:0]  ACC_MAX       = {ACC_W{1'b1}};
  // 1000.0 squared with 24 fraction bits
  localparam logic [ACC_W-1:0]  MISMATCH_DIST = 48'd16777216000000;
  // 10.0 squared with 24 fraction bits
  localparam logic [ACC_W-1:0]  THRESH_RESET  = 48'd1677721600;
  localparam logic [ECNT_W-1:0] ECNT_MAX      = {ECNT_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_QUERY  = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_DECIDE = 2'd2
  } kind_e;

  // entry element after address issue, heading for the distance unit
  typedef struct packed {
    logic                    last;
    logic                    in_range;
    logic                    mismatch;
    logic [ID_W-1:0]         id;
    logic signed [VAL_W-1:0] value;
  } elem_t;

endpackage

// ===== rtl/nvmt_query_mem.sv =====
// ----------------------------------------------------------------------------
// nvmt_query_mem
// Query vector store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nvmt_query_mem
  import nvmt_pkg::*;
#(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = 7
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [VAL_W-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [VAL_W-1:0]  rdata_o
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/nvmt_dist_unit.sv =====
// ----------------------------------------------------------------------------
// nvmt_dist_unit
// Difference, square and saturating accumulate per element; best entry
// tracking against the threshold at the end of each entry.
// ----------------------------------------------------------------------------
module nvmt_dist_unit
  import nvmt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             elem_valid_i,
  input  elem_t            elem_i,
  input  logic [VAL_W-1:0] query_val_i,
  input  logic [ACC_W-1:0] threshold_i,
  input  logic             clear_i,
  output logic             busy_o,
  output logic             have_match_o,
  output logic [ID_W-1:0]  best_id_o,
  output logic [ACC_W-1:0] best_dist_o
);

  // square stage
  logic                    sq_valid_q;
  logic                    sq_last_q;
  logic                    sq_in_range_q;
  logic                    sq_mismatch_q;
  logic [ID_W-1:0]         sq_id_q;
  logic [SQ_W-1:0]         sq_q;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_abs;
  logic [MAG_W-1:0]         mag;

  // accumulate stage
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0] best_dist_q, best_dist_d;
  logic [ID_W-1:0]  best_id_q, best_id_d;
  logic             have_match_q, have_match_d;
  logic [ACC_W:0]   sum;
  logic [ACC_W-1:0] acc_sum;
  logic [ACC_W-1:0] ent_dist;

  always_comb begin
    diff     = DIFF_W'($signed(elem_i.value)) - DIFF_W'($signed(query_val_i));
    diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    mag      = diff_abs[MAG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
    end else begin
      sq_valid_q <= elem_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (elem_valid_i) begin
      sq_last_q     <= elem_i.last;
      sq_in_range_q <= elem_i.in_range;
      sq_mismatch_q <= elem_i.mismatch;
      sq_id_q       <= elem_i.id;
      sq_q          <= mag * mag;
    end
  end

  always_comb begin
    sum          = {1'b0, acc_q} + (ACC_W+1)'(sq_q);
    acc_sum      = !sq_in_range_q ? ACC_MAX :
                   (sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0]);
    ent_dist     = sq_mismatch_q ? MISMATCH_DIST : acc_sum;
    acc_d        = acc_q;
    best_dist_d  = best_dist_q;
    best_id_d    = best_id_q;
    have_match_d = have_match_q;
    if (clear_i) begin
      acc_d        = '0;
      best_dist_d  = MISMATCH_DIST;
      best_id_d    = '0;
      have_match_d = 1'b0;
    end else if (sq_valid_q) begin
      if (sq_last_q) begin
        acc_d = '0;
        if (ent_dist < threshold_i && ent_dist < best_dist_q) begin
          best_dist_d  = ent_dist;
          best_id_d    = sq_id_q;
          have_match_d = 1'b1;
        end
      end else begin
        acc_d = acc_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      best_dist_q  <= MISMATCH_DIST;
      best_id_q    <= '0;
      have_match_q <= 1'b0;
    end else begin
      acc_q        <= acc_d;
      best_dist_q  <= best_dist_d;
      best_id_q    <= best_id_d;
      have_match_q <= have_match_d;
    end
  end

  assign busy_o       = sq_valid_q;
  assign have_match_o = have_match_q;
  assign best_id_o    = best_id_q;
  assign best_dist_o  = best_dist_q;

endmodule

// ===== rtl/nearest_vector_match_threshold_core.sv =====
// ----------------------------------------------------------------------------
// nearest_vector_match_threshold_core
// Loads a query vector into a small memory, streams stored entries against
// it accumulating squared euclidean distance, reports the closest entry under
// the threshold on a decide request.
//
//   channel | handshake                 | payload
//   --------+---------------------------+-------------------------------------
//   in      | in_valid_i / in_ready_o   | kind, element_value, entry_id,
//           |                           | last_element
//   out     | out_valid_o / out_ready_i | match_found, match_id,
//           |                           | match_distance_squared
//   cfg     | cfg_valid_i / cfg_ready_o | threshold_squared
//
// query and entry element requests are taken one per cycle; an entry element
// passes query memory read, square and accumulate. a decide request waits until
// the memory read and square stages have drained and the output register is
// free, which it is not while an earlier result is still held. the output
// register holds its result while out_ready_i is low; element requests keep
// flowing meanwhile. no clearing pass after reset.
// ----------------------------------------------------------------------------
module nearest_vector_match_threshold_core
  import nvmt_pkg::*;
#(
  parameter int unsigned MAX_VECTOR_LENGTH = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [VAL_W-1:0]  element_value_i,
  input  logic [ID_W-1:0]   entry_id_i,
  input  logic              last_element_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              match_found_o,
  output logic [ID_W-1:0]   match_id_o,
  output logic [ACC_W-1:0]  match_distance_squared_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ACC_W-1:0]  threshold_squared_i
);

  localparam int unsigned LEN_W  = $clog2(MAX_VECTOR_LENGTH + 1);
  localparam int unsigned ADDR_W = (MAX_VECTOR_LENGTH > 1) ? $clog2(MAX_VECTOR_LENGTH) : 1;
  localparam int unsigned CMP_W  = ECNT_W + 1;

  logic [ACC_W-1:0]  thresh_q;
  logic [LEN_W-1:0]  qlen_q, qlen_d;
  logic [LEN_W-1:0]  load_cnt_q, load_cnt_d;
  logic [ECNT_W-1:0] ent_cnt_q, ent_cnt_d;

  logic              elem_valid_q;
  elem_t             elem_q;

  logic              out_valid_q;
  logic              match_found_q;
  logic [ID_W-1:0]   match_id_q;
  logic [ACC_W-1:0]  match_dist_q;

  logic              accept;
  logic              is_query, is_entry, is_decide;
  logic              pipe_empty;
  logic              out_free;
  logic              load_room;
  logic [LEN_W-1:0]  load_next;
  logic              ent_in_range;
  logic              ent_mismatch;
  logic              mem_we;
  logic              mem_re;
  logic [VAL_W-1:0]  mem_rdata;
  logic              dist_busy;
  logic              have_match;
  logic [ID_W-1:0]   best_id;
  logic [ACC_W-1:0]  best_dist;

  assign is_query  = (kind_i == KIND_QUERY);
  assign is_entry  = (kind_i == KIND_ENTRY);
  assign is_decide = (kind_i == KIND_DECIDE);

  assign pipe_empty = !elem_valid_q && !dist_busy;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !is_decide || (pipe_empty && out_free);
  assign accept     = in_valid_i && in_ready_o;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_valid_i) begin
      thresh_q <= threshold_squared_i;
    end
  end

  // query load side
  assign load_room = (load_cnt_q < LEN_W'(MAX_VECTOR_LENGTH));
  assign load_next = load_room ? LEN_W'(load_cnt_q + LEN_W'(1)) : load_cnt_q;
  assign mem_we    = accept && is_query && load_room;

  // entry side: range and length checks against the query length right now
  assign ent_in_range = (CMP_W'(ent_cnt_q) < CMP_W'(qlen_q)) &&
                        (CMP_W'(ent_cnt_q) < CMP_W'(MAX_VECTOR_LENGTH));
  assign ent_mismatch = ((CMP_W'(ent_cnt_q) + CMP_W'(1)) != CMP_W'(qlen_q));
  assign mem_re       = accept && is_entry && ent_in_range;

  always_comb begin
    qlen_d     = qlen_q;
    load_cnt_d = load_cnt_q;
    ent_cnt_d  = ent_cnt_q;
    if (accept) begin
      priority if (is_query) begin
        load_cnt_d = load_next;
        if (last_element_i) begin
          qlen_d     = load_next;
          load_cnt_d = '0;
        end
      end else if (is_entry) begin
        if (last_element_i) begin
          ent_cnt_d = '0;
        end else if (ent_cnt_q != ECNT_MAX) begin
          ent_cnt_d = ent_cnt_q + ECNT_W'(1);
        end
      end else if (is_decide) begin
        ent_cnt_d = '0;
      end else begin
        ent_cnt_d = ent_cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_q       <= '0;
      load_cnt_q   <= '0;
      ent_cnt_q    <= '0;
      elem_valid_q <= 1'b0;
    end else begin
      qlen_q       <= qlen_d;
      load_cnt_q   <= load_cnt_d;
      ent_cnt_q    <= ent_cnt_d;
      elem_valid_q <= accept && is_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_entry) begin
      elem_q.last     <= last_element_i;
      elem_q.in_range <= ent_in_range;
      elem_q.mismatch <= ent_mismatch;
      elem_q.id       <= entry_id_i;
      elem_q.value    <= element_value_i;
    end
  end

  nvmt_query_mem #(
    .DEPTH  (MAX_VECTOR_LENGTH),
    .ADDR_W (ADDR_W)
  ) u_query_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (load_cnt_q[ADDR_W-1:0]),
    .wdata_i (element_value_i),
    .re_i    (mem_re),
    .raddr_i (ent_cnt_q[ADDR_W-1:0]),
    .rdata_o (mem_rdata)
  );

  nvmt_dist_unit u_dist_unit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .elem_valid_i (elem_valid_q),
    .elem_i       (elem_q),
    .query_val_i  (mem_rdata),
    .threshold_i  (thresh_q),
    .clear_i      (accept && is_decide),
    .busy_o       (dist_busy),
    .have_match_o (have_match),
    .best_id_o    (best_id),
    .best_dist_o  (best_dist)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && is_decide) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_decide) begin
      match_found_q <= have_match;
      match_id_q    <= have_match ? best_id : '0;
      match_dist_q  <= best_dist;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign match_found_o            = match_found_q;
  assign match_id_o               = match_id_q;
  assign match_distance_squared_o = match_dist_q;

endmodule
